@@ rtl/hbls_pkg.sv @@
// Shared types and constants for the heartbeat link supervisor.
// No dependencies; every other file imports this package.
`default_nettype none

package hbls_pkg;

  // Operation codes carried in the mode field of an input word
  typedef enum logic [2:0] {
    MODE_HEARTBEAT = 3'd0,
    MODE_SCAN      = 3'd1,
    MODE_STALL     = 3'd2,
    MODE_TAKE_GAP  = 3'd3,
    MODE_DISARM    = 3'd4
  } mode_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINK_TIMEOUT = 3'd0,
    CFG_STOP_LIMIT   = 3'd1,
    CFG_ATTRIBUTION  = 3'd2,
    CFG_CLOSED_LOOP  = 3'd3,
    CFG_IDLE_CODE    = 3'd4
  } cfg_idx_t;

  // Configuration reset values
  localparam logic [15:0] RST_LINK_TIMEOUT = 16'd500;
  localparam logic [15:0] RST_STOP_LIMIT   = 16'd1000;
  localparam logic [15:0] RST_ATTRIBUTION  = 16'd250;
  localparam logic [7:0]  RST_CLOSED_LOOP  = 8'd8;
  localparam logic [7:0]  RST_IDLE_CODE    = 8'd1;

  // Heartbeats shorter than this many bytes are ignored
  localparam logic [3:0] MIN_HB_LEN = 4'd5;

  localparam logic [15:0] DROP_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] link_timeout_ms;
    logic [15:0] stop_limit_ms;
    logic [15:0] attribution_ms;
    logic [7:0]  closed_loop_code;
    logic [7:0]  idle_code;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic [31:0] blind_ms;
    logic [3:0]  frame_len;
    logic [31:0] hb_error;
    logic [7:0]  hb_state;
  } in_word_t;

  typedef struct packed {
    logic        link_up;
    logic        fresh;
    logic        stop_latched;
    logic        stop_request;
    logic        link_lost;
    logic        link_established;
    logic [15:0] drop_count;
    logic [31:0] gap_report;
    logic [31:0] session_worst_gap;
    logic        state_changed;
    logic        unexplained_idle;
    logic        error_changed;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/hbls_if.sv @@
// Valid/ready channel interfaces for input and result words.
// Depends on hbls_pkg for the payload types.
`default_nettype none

interface hbls_in_if;
  import hbls_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hbls_out_if;
  import hbls_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/hbls_cfg.sv @@
// Configuration register file: write-only, indexed, with reset values.
// Depends on hbls_pkg.
`default_nettype none

module hbls_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [hbls_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [hbls_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output hbls_pkg::cfg_t                        cfg
);
  import hbls_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_LINK_TIMEOUT: cfg_nxt.link_timeout_ms  = cfg_wdata;
        CFG_STOP_LIMIT:   cfg_nxt.stop_limit_ms    = cfg_wdata;
        CFG_ATTRIBUTION:  cfg_nxt.attribution_ms   = cfg_wdata;
        CFG_CLOSED_LOOP:  cfg_nxt.closed_loop_code = cfg_wdata[7:0];
        CFG_IDLE_CODE:    cfg_nxt.idle_code        = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.link_timeout_ms  <= RST_LINK_TIMEOUT;
      cfg_r.stop_limit_ms    <= RST_STOP_LIMIT;
      cfg_r.attribution_ms   <= RST_ATTRIBUTION;
      cfg_r.closed_loop_code <= RST_CLOSED_LOOP;
      cfg_r.idle_code        <= RST_IDLE_CODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/hbls_core.sv @@
// Link state and per-word update logic: gap tracking, freshness, drops,
// safety stop, stall credit and edge pulses. Depends on hbls_pkg.
`default_nettype none

module hbls_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire hbls_pkg::in_word_t word,
  input  wire hbls_pkg::cfg_t     cfg,
  output hbls_pkg::out_word_t     res
);
  import hbls_pkg::*;

  // State
  logic [31:0] prev_hb_r,      prev_hb_nxt;
  logic        gap_valid_r,    gap_valid_nxt;
  logic [31:0] win_gap_r,      win_gap_nxt;
  logic [31:0] sess_gap_r,     sess_gap_nxt;
  logic [15:0] credit_r,       credit_nxt;
  logic [31:0] last_hb_r,      last_hb_nxt;
  logic [31:0] last_disarm_r,  last_disarm_nxt;
  logic        up_r,           up_nxt;
  logic        ever_r,         ever_nxt;
  logic        stop_sent_r,    stop_sent_nxt;
  logic        stopped_r,      stopped_nxt;
  logic [15:0] drops_r,        drops_nxt;
  logic        axis_seen_r,    axis_seen_nxt;
  logic [7:0]  prev_axis_r,    prev_axis_nxt;
  logic        err_seen_r,     err_seen_nxt;
  logic [31:0] prev_err_r,     prev_err_nxt;

  // Datapath terms
  logic [31:0] age_diff;
  logic [31:0] age;
  logic        fresh_c;
  logic        stop_due;
  logic [31:0] gap;
  logic [31:0] sess_upd;
  logic [31:0] disarm_age;
  logic [15:0] room;
  logic [15:0] grant;
  logic [31:0] credited;
  logic [31:0] ahead;
  logic        hb_ok;

  // Heartbeat age: signed difference, floored at zero
  assign age_diff = word.now_ms - last_hb_r;
  assign age      = (age_diff == 32'd0 || age_diff[31]) ? 32'd0 : age_diff;
  assign fresh_c  = age < {16'd0, cfg.link_timeout_ms};
  assign stop_due = (cfg.stop_limit_ms != 16'd0) && ever_r && !stop_sent_r &&
                    (age >= {16'd0, cfg.stop_limit_ms});

  // Inter-frame gap and attribution window
  assign gap        = word.now_ms - prev_hb_r;
  assign sess_upd   = (gap_valid_r && gap > sess_gap_r) ? gap : sess_gap_r;
  assign disarm_age = word.now_ms - last_disarm_r;
  assign hb_ok      = word.frame_len >= MIN_HB_LEN;

  // Stall credit, bounded by the stop limit and clamped to now
  assign room     = cfg.stop_limit_ms - credit_r;
  assign grant    = (word.blind_ms > {16'd0, room}) ? room : word.blind_ms[15:0];
  assign credited = last_hb_r + {16'd0, grant};
  assign ahead    = credited - word.now_ms;

  // Next state and result word
  always_comb begin
    prev_hb_nxt     = prev_hb_r;
    gap_valid_nxt   = gap_valid_r;
    win_gap_nxt     = win_gap_r;
    sess_gap_nxt    = sess_gap_r;
    credit_nxt      = credit_r;
    last_hb_nxt     = last_hb_r;
    last_disarm_nxt = last_disarm_r;
    up_nxt          = up_r;
    ever_nxt        = ever_r;
    stop_sent_nxt   = stop_sent_r;
    stopped_nxt     = stopped_r;
    drops_nxt       = drops_r;
    axis_seen_nxt   = axis_seen_r;
    prev_axis_nxt   = prev_axis_r;
    err_seen_nxt    = err_seen_r;
    prev_err_nxt    = prev_err_r;
    res             = '0;

    if (go) begin
      unique case (mode_t'(word.mode))
        MODE_HEARTBEAT: begin
          if (hb_ok) begin
            if (gap_valid_r && gap > win_gap_r) win_gap_nxt = gap;
            sess_gap_nxt  = up_r ? sess_upd : 32'd0;
            prev_hb_nxt   = word.now_ms;
            gap_valid_nxt = 1'b1;
            credit_nxt    = 16'd0;
            up_nxt        = 1'b1;
            ever_nxt      = 1'b1;
            stop_sent_nxt = 1'b0;
            stopped_nxt   = 1'b0;
            res.link_established = !up_r;
            if (!axis_seen_r || prev_axis_r != word.hb_state) begin
              res.state_changed    = 1'b1;
              res.unexplained_idle = axis_seen_r &&
                                     word.hb_state == cfg.idle_code &&
                                     prev_axis_r == cfg.closed_loop_code &&
                                     disarm_age >= {16'd0, cfg.attribution_ms};
              axis_seen_nxt = 1'b1;
              prev_axis_nxt = word.hb_state;
            end
            if (!err_seen_r || prev_err_r != word.hb_error) begin
              res.error_changed = 1'b1;
              err_seen_nxt      = 1'b1;
              prev_err_nxt      = word.hb_error;
            end
            last_hb_nxt = word.now_ms;
          end
        end
        MODE_SCAN: begin
          res.fresh = fresh_c;
          // Drop the link when a stale scan finds it up
          if (up_r && !fresh_c) begin
            up_nxt        = 1'b0;
            res.link_lost = 1'b1;
            gap_valid_nxt = 1'b0;
            if (drops_r != DROP_MAX) drops_nxt = drops_r + 16'd1;
          end
          // Fire the one-shot stop
          if (stop_due) begin
            stop_sent_nxt    = 1'b1;
            stopped_nxt      = 1'b1;
            last_disarm_nxt  = word.now_ms;
            res.stop_request = 1'b1;
          end
        end
        MODE_STALL: begin
          if (credit_r < cfg.stop_limit_ms) begin
            credit_nxt    = credit_r + grant;
            last_hb_nxt   = (ahead != 32'd0 && !ahead[31]) ? word.now_ms : credited;
            gap_valid_nxt = 1'b0;
          end
        end
        MODE_TAKE_GAP: begin
          res.gap_report = win_gap_r;
          win_gap_nxt    = 32'd0;
        end
        MODE_DISARM: begin
          last_disarm_nxt = word.now_ms;
        end
        default: ;
      endcase
    end

    // Status after the update
    res.link_up           = up_nxt;
    res.stop_latched      = stopped_nxt;
    res.drop_count        = drops_nxt;
    res.session_worst_gap = sess_gap_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_hb_r     <= '0;
      gap_valid_r   <= 1'b0;
      win_gap_r     <= '0;
      sess_gap_r    <= '0;
      credit_r      <= '0;
      last_hb_r     <= '0;
      last_disarm_r <= '0;
      up_r          <= 1'b0;
      ever_r        <= 1'b0;
      stop_sent_r   <= 1'b0;
      stopped_r     <= 1'b0;
      drops_r       <= '0;
      axis_seen_r   <= 1'b0;
      prev_axis_r   <= '0;
      err_seen_r    <= 1'b0;
      prev_err_r    <= '0;
    end else begin
      prev_hb_r     <= prev_hb_nxt;
      gap_valid_r   <= gap_valid_nxt;
      win_gap_r     <= win_gap_nxt;
      sess_gap_r    <= sess_gap_nxt;
      credit_r      <= credit_nxt;
      last_hb_r     <= last_hb_nxt;
      last_disarm_r <= last_disarm_nxt;
      up_r          <= up_nxt;
      ever_r        <= ever_nxt;
      stop_sent_r   <= stop_sent_nxt;
      stopped_r     <= stopped_nxt;
      drops_r       <= drops_nxt;
      axis_seen_r   <= axis_seen_nxt;
      prev_axis_r   <= prev_axis_nxt;
      err_seen_r    <= err_seen_nxt;
      prev_err_r    <= prev_err_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/heartbeat_link_supervisor.sv @@
// Top level of the heartbeat link supervisor: input register, core, result register.
// Depends on hbls_pkg, hbls_if, hbls_cfg and hbls_core.
`default_nettype none

// Heartbeat link supervisor. Every accepted input word (heartbeat, scan, stall
// credit, gap take or disarm record) yields exactly one result word. The block
// takes one word per clock while the result side keeps up: a word waits in the
// input register until the core updates the link state from it, and its result
// is captured in the output register in the same cycle, to be offered from
// there. The result register lets a new word in while a finished result waits
// to be taken. Configuration writes through cfg_we/cfg_idx/cfg_wdata take
// effect on the next cycle and should be made while no word is in flight.

module heartbeat_link_supervisor (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  hbls_in_if.sink                               in_if,
  hbls_out_if.source                            out_if,
  input  wire logic                             cfg_we,
  input  wire logic [hbls_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [hbls_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hbls_pkg::*;

  cfg_t      cfg;
  in_word_t  in_word_r;
  logic      in_valid_r;
  out_word_t out_word_r;
  logic      out_valid_r;
  out_word_t res;
  logic      advance;
  logic      in_take;

  hbls_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hbls_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (advance),
    .word  (in_word_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Move a word on when the result register is free or being drained
  assign advance     = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;
  assign in_take     = in_if.valid && in_if.ready;

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_if.data;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= res;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_word_r;

  // A newly established link reports itself up
  a_estab_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.data.link_established) |-> out_if.data.link_up)
    else $error("link_established without link_up");

  // A lost link reports itself down
  a_lost_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.data.link_lost) |-> !out_if.data.link_up)
    else $error("link_lost with link_up");

  // A stop request always leaves the stop latched
  a_stop_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.data.stop_request) |-> out_if.data.stop_latched)
    else $error("stop_request without stop_latched");

  // An unexplained idle is always a state change on a heartbeat
  a_idle_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.data.unexplained_idle) |->
      (out_if.data.state_changed && !out_if.data.fresh))
    else $error("unexplained_idle without state_changed");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking bench for heartbeat_link_supervisor: directed cases, random event
// traffic under several register settings and a run of repeated link drops.
// Depends on hbls_pkg, hbls_if and the RTL top level.
`timescale 1ns / 100ps

module tb;
  import hbls_pkg::*;

  // Mode codes the block must ignore
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned TRAFFIC_ITEMS = 140;
  localparam int unsigned DROP_RUNS = 16;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hbls_in_if  in_ch ();
  hbls_out_if out_ch ();

  heartbeat_link_supervisor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Register copies
  logic [15:0] lim_timeout, lim_stop, lim_attr;
  logic [7:0]  lim_closed, lim_idle;

  // Link state copies
  logic [31:0] prev_hb_ms, window_gap, session_gap, credit_ms, last_hb_ms, disarm_ms;
  logic        gap_ok, session_open, link_up, link_ever, stop_sent, stopped;
  logic [15:0] drops;
  logic        axis_seen, err_seen;
  logic [7:0]  last_axis;
  logic [31:0] last_err;

  out_word_t pending_status[$];

  // Stimulus bookkeeping
  bit          src_pacing = 1'b1;
  bit          sink_pacing = 1'b1;
  logic [31:0] traffic_ms = '0;
  logic [7:0]  last_axis_sent = '0;
  logic [31:0] err_word_sent = '0;

  int unsigned errors = 0, checked = 0, sent = 0, settings_used = 0;
  int unsigned established_seen = 0, lost_seen = 0, stops_seen = 0, idles_seen = 0;
  int unsigned quiet_cycles = 0;

  task automatic reset_link_model();
    lim_timeout = RST_LINK_TIMEOUT;
    lim_stop = RST_STOP_LIMIT;
    lim_attr = RST_ATTRIBUTION;
    lim_closed = RST_CLOSED_LOOP;
    lim_idle = RST_IDLE_CODE;
    prev_hb_ms = '0; window_gap = '0; session_gap = '0;
    credit_ms = '0; last_hb_ms = '0; disarm_ms = '0;
    gap_ok = 1'b0; session_open = 1'b0; link_up = 1'b0; link_ever = 1'b0;
    stop_sent = 1'b0; stopped = 1'b0; drops = '0;
    axis_seen = 1'b0; last_axis = '0; err_seen = 1'b0; last_err = '0;
  endtask

  // Heartbeat age: wrapping difference, negative or zero reads as zero
  function automatic logic [31:0] hb_age_at(logic [31:0] now);
    logic [31:0] d;
    d = now - last_hb_ms;
    return (d[31] || d == '0) ? '0 : d;
  endfunction

  // Advance the link state by one word and return the status it produces
  function automatic out_word_t predict_status(in_word_t w);
    out_word_t r;
    logic [31:0] gap, age, room, grant, credited, ahead;
    r = '0;
    case (w.mode)
      MODE_HEARTBEAT: begin
        if (w.frame_len >= MIN_HB_LEN) begin
          if (gap_ok) begin
            gap = w.now_ms - prev_hb_ms;
            if (gap > window_gap) window_gap = gap;
            if (gap > session_gap) session_gap = gap;
          end
          prev_hb_ms = w.now_ms;
          gap_ok = 1'b1;
          credit_ms = '0;
          link_up = 1'b1;
          link_ever = 1'b1;
          stop_sent = 1'b0;
          stopped = 1'b0;
          if (!session_open) begin
            session_open = 1'b1;
            r.link_established = 1'b1;
            session_gap = '0;
          end
          if (!axis_seen || last_axis != w.hb_state) begin
            r.state_changed = 1'b1;
            // closed loop dropping to idle outside our own disarm window
            if (axis_seen && w.hb_state == lim_idle && last_axis == lim_closed &&
                (w.now_ms - disarm_ms) >= {16'd0, lim_attr})
              r.unexplained_idle = 1'b1;
            axis_seen = 1'b1;
            last_axis = w.hb_state;
          end
          if (!err_seen || last_err != w.hb_error) begin
            r.error_changed = 1'b1;
            err_seen = 1'b1;
            last_err = w.hb_error;
          end
          last_hb_ms = w.now_ms;
        end
      end
      MODE_SCAN: begin
        age = hb_age_at(w.now_ms);
        r.fresh = age < {16'd0, lim_timeout};
        if (link_up && !r.fresh) begin
          link_up = 1'b0;
          if (drops != DROP_MAX) drops = drops + 1'b1;
          if (session_open) begin
            session_open = 1'b0;
            r.link_lost = 1'b1;
          end
          gap_ok = 1'b0;
        end
        if (lim_stop != '0 && link_ever && !stop_sent && age >= {16'd0, lim_stop}) begin
          stop_sent = 1'b1;
          stopped = 1'b1;
          disarm_ms = w.now_ms;
          r.stop_request = 1'b1;
        end
      end
      MODE_STALL: begin
        if (credit_ms < {16'd0, lim_stop}) begin
          room = {16'd0, lim_stop} - credit_ms;
          grant = (w.blind_ms > room) ? room : w.blind_ms;
          credited = last_hb_ms + grant;
          ahead = credited - w.now_ms;
          credit_ms = credit_ms + grant;
          // never credit past the current time
          last_hb_ms = (ahead != '0 && !ahead[31]) ? w.now_ms : credited;
          gap_ok = 1'b0;
        end
      end
      MODE_TAKE_GAP: begin
        r.gap_report = window_gap;
        window_gap = '0;
      end
      MODE_DISARM: disarm_ms = w.now_ms;
      default: ;
    endcase
    r.link_up = link_up;
    r.stop_latched = stopped;
    r.drop_count = drops;
    r.session_worst_gap = session_gap;
    return r;
  endfunction

  function automatic string field_mismatches(out_word_t e, out_word_t g);
    string s;
    s = "";
    if (g.link_up !== e.link_up) s = {s, " link_up"};
    if (g.fresh !== e.fresh) s = {s, " fresh"};
    if (g.stop_latched !== e.stop_latched) s = {s, " stop_latched"};
    if (g.stop_request !== e.stop_request) s = {s, " stop_request"};
    if (g.link_lost !== e.link_lost) s = {s, " link_lost"};
    if (g.link_established !== e.link_established) s = {s, " link_established"};
    if (g.drop_count !== e.drop_count) s = {s, " drop_count"};
    if (g.gap_report !== e.gap_report) s = {s, " gap_report"};
    if (g.session_worst_gap !== e.session_worst_gap) s = {s, " session_worst_gap"};
    if (g.state_changed !== e.state_changed) s = {s, " state_changed"};
    if (g.unexplained_idle !== e.unexplained_idle) s = {s, " unexplained_idle"};
    if (g.error_changed !== e.error_changed) s = {s, " error_changed"};
    return s;
  endfunction

  // Word builders; fields the mode does not use carry random bits
  function automatic in_word_t hb_word(logic [31:0] now, logic [3:0] len,
                                       logic [31:0] err, logic [7:0] axis);
    in_word_t w;
    w.mode = MODE_HEARTBEAT;
    w.now_ms = now;
    w.blind_ms = $urandom;
    w.frame_len = len;
    w.hb_error = err;
    w.hb_state = axis;
    return w;
  endfunction

  function automatic in_word_t op_word(logic [2:0] mode, logic [31:0] now, logic [31:0] stall);
    in_word_t w;
    w.mode = mode;
    w.now_ms = now;
    w.blind_ms = stall;
    w.frame_len = 4'($urandom_range(0, 8));
    w.hb_error = $urandom;
    w.hb_state = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // Heartbeat with a plausible axis state and a mostly steady error word
  function automatic in_word_t next_heartbeat(logic [31:0] now);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) last_axis_sent = lim_closed;
    else if (r < 7) last_axis_sent = lim_idle;
    else if (r == 9) last_axis_sent = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 9);
    if (r == 8) err_word_sent = $urandom;
    else if (r == 9) err_word_sent = '0;
    return hb_word(now, 4'($urandom_range(5, 8)), err_word_sent, last_axis_sent);
  endfunction

  // Time step between events, biased toward the register thresholds
  function automatic logic [31:0] next_step();
    logic [31:0] tmo, stp, att;
    int unsigned r;
    tmo = {16'd0, lim_timeout};
    stp = {16'd0, lim_stop};
    att = {16'd0, lim_attr};
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 10) return $urandom_range(0, tmo);
    if (r < 12) return tmo + $urandom_range(0, 2) - 1;
    if (r < 14) return stp + $urandom_range(0, 2) - 1;
    if (r < 16) return att + $urandom_range(0, 2) - 1;
    if (r < 19) return $urandom_range(0, 3 * stp + 3);
    return $urandom;
  endfunction

  // Send one word and record the status it must produce
  task automatic send_word(input in_word_t w);
    int unsigned pause;
    out_word_t status;
    pause = src_pacing ? $urandom_range(0, 13) : 0;
    if (pause != 0) begin
      in_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    status = predict_status(w);
    sent++;
    established_seen += status.link_established;
    lost_seen += status.link_lost;
    stops_seen += status.stop_request;
    idles_seen += status.unexplained_idle;
    pending_status.push_back(status);
  endtask

  // Drop valid and hold until every outstanding status word has come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    wait (pending_status.size() == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LINK_TIMEOUT: lim_timeout = val;
      CFG_STOP_LIMIT:   lim_stop = val;
      CFG_ATTRIBUTION:  lim_attr = val;
      CFG_CLOSED_LOOP:  lim_closed = val[7:0];
      CFG_IDLE_CODE:    lim_idle = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] timeout, input logic [15:0] stop_lim,
                                input logic [15:0] attr, input logic [7:0] closed,
                                input logic [7:0] idle);
    wait_idle();
    write_reg(CFG_LINK_TIMEOUT, timeout);
    write_reg(CFG_STOP_LIMIT, stop_lim);
    write_reg(CFG_ATTRIBUTION, attr);
    write_reg(CFG_CLOSED_LOOP, {8'd0, closed});
    write_reg(CFG_IDLE_CODE, {8'd0, idle});
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Reset values: edges, short frames, stall credit, gap take, disarm, one-shot stop, unused modes
  task automatic test_directed_cases();
    send_word(op_word(MODE_SCAN, 32'd0, 32'd0));
    send_word(op_word(MODE_SCAN, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(hb_word(32'd100, 4'd4, 32'h1234_5678, 8'd8));
    send_word(hb_word(32'd100, 4'd0, 32'h0, 8'd0));
    send_word(op_word(MODE_STALL, 32'd0, 32'hFFFF_FFFF));
    send_word(hb_word(32'd1000, 4'd5, 32'h0, RST_CLOSED_LOOP));
    send_word(hb_word(32'd1200, 4'd8, 32'hFFFF_FFFF, RST_CLOSED_LOOP));
    send_word(hb_word(32'd1400, 4'd8, 32'hFFFF_FFFF, RST_IDLE_CODE));
    send_word(hb_word(32'd1500, 4'd6, 32'hFFFF_FFFF, RST_CLOSED_LOOP));
    send_word(op_word(MODE_DISARM, 32'd1600, 32'd0));
    send_word(hb_word(32'd1700, 4'd7, 32'hFFFF_FFFF, RST_IDLE_CODE));
    send_word(op_word(MODE_TAKE_GAP, 32'd1700, 32'd0));
    send_word(op_word(MODE_TAKE_GAP, 32'd1700, 32'd0));
    send_word(op_word(MODE_SCAN, 32'd2199, 32'd0));
    send_word(op_word(MODE_SCAN, 32'd2200, 32'd0));
    send_word(op_word(MODE_SCAN, 32'd2700, 32'd0));
    send_word(op_word(MODE_SCAN, 32'd2800, 32'd0));
    send_word(op_word(MODE_STALL, 32'd2800, 32'd100));
    send_word(op_word(MODE_STALL, 32'd2800, 32'hFFFF_FFFF));
    send_word(op_word(MODE_STALL, 32'd2800, 32'hFFFF_FFFF));
    send_word(hb_word(32'hFFFF_FFFF, 4'd8, 32'h0, 8'hFF));
    send_word(op_word(MODE_SCAN, 32'd0, 32'd0));
    send_word(hb_word(32'd10, 4'd8, 32'hA5A5_5A5A, 8'hFF));
    for (logic [3:0] m = {1'b0, MODE_UNUSED_FIRST}; m <= {1'b0, MODE_UNUSED_LAST}; m++)
      send_word(op_word(m[2:0], $urandom, $urandom));
  endtask

  // Random event traffic: mostly plausible timelines, some noise
  task automatic test_traffic(input int unsigned count);
    int unsigned done_items, pick;
    done_items = 0;
    while (done_items < count) begin
      if (done_items % 64 == 0) begin
        src_pacing = $urandom_range(0, 3) != 0;
        sink_pacing = $urandom_range(0, 3) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        traffic_ms += next_step();
        send_word(next_heartbeat(traffic_ms));
        done_items++;
      end else if (pick < 63) begin
        traffic_ms += next_step();
        send_word(op_word(MODE_SCAN, traffic_ms, $urandom));
        done_items++;
      end else if (pick < 70) begin
        send_word(op_word(MODE_STALL, traffic_ms + $urandom_range(0, 3),
                          ($urandom_range(0, 3) == 0) ? $urandom :
                          $urandom_range(0, 2 * {16'd0, lim_stop} + 1)));
        done_items++;
      end else if (pick < 76) begin
        send_word(op_word(MODE_TAKE_GAP, traffic_ms, $urandom));
        done_items++;
      end else if (pick < 83) begin
        traffic_ms += $urandom_range(0, {16'd0, lim_attr});
        send_word(op_word(MODE_DISARM, traffic_ms, $urandom));
        done_items++;
      end else if (pick < 92) begin
        // closed loop then idle, with or without our own disarm in between
        traffic_ms += next_step();
        send_word(hb_word(traffic_ms, 4'd8, err_word_sent, lim_closed));
        if ($urandom_range(0, 1) == 1) begin
          traffic_ms += $urandom_range(0, {16'd0, lim_attr});
          send_word(op_word(MODE_DISARM, traffic_ms, $urandom));
          done_items++;
        end
        traffic_ms += $urandom_range(0, 2 * {16'd0, lim_attr} + 2);
        send_word(hb_word(traffic_ms, 4'd5, err_word_sent, lim_idle));
        last_axis_sent = lim_idle;
        done_items += 2;
      end else begin
        case ($urandom_range(0, 2))
          0: send_word(hb_word($urandom, 4'($urandom_range(0, 4)), $urandom,
                               8'($urandom_range(0, 255))));
          1: send_word(op_word(3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
                               $urandom, $urandom));
          default: begin
            send_word(op_word(3'($urandom_range(MODE_HEARTBEAT, MODE_DISARM)),
                              $urandom, $urandom));
            done_items++;
          end
        endcase
      end
    end
  endtask

  // Lose and regain the link back to back with no pacing on either side
  task automatic test_repeated_drops();
    apply_settings(16'd1, 16'd0, RST_ATTRIBUTION, RST_CLOSED_LOOP, RST_IDLE_CODE);
    src_pacing = 1'b0;
    sink_pacing = 1'b0;
    for (int unsigned i = 0; i < DROP_RUNS; i++) begin
      traffic_ms += 2;
      send_word(next_heartbeat(traffic_ms));
      send_word(op_word(MODE_SCAN, traffic_ms + 1, $urandom));
    end
    src_pacing = 1'b1;
    sink_pacing = 1'b1;
  endtask

  // Result side: random stalls on ready
  initial begin : status_sink
    int unsigned hold;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = sink_pacing ? $urandom_range(0, 13) : 0;
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Compare each status word against the oldest prediction
  always @(posedge clk) begin : status_check
    out_word_t want;
    string bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_status.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("unexpected status word %h", out_ch.data);
      end else begin
        want = pending_status.pop_front();
        bad = field_mismatches(want, out_ch.data);
        if (bad != "") begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("status word %0d wrong in%s: expected %h, got %h",
                     checked, bad, want, out_ch.data);
        end
        checked++;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, %0d words outstanding",
               quiet_cycles, pending_status.size());
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_LINK_TIMEOUT;
    cfg_wdata <= '0;
    reset_link_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    apply_settings(16'd1, 16'd0, 16'd0, 8'd0, 8'hFF);
    test_traffic(TRAFFIC_ITEMS);
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'd0);
    test_traffic(TRAFFIC_ITEMS);
    apply_settings(RST_LINK_TIMEOUT, RST_STOP_LIMIT, RST_ATTRIBUTION,
                   RST_CLOSED_LOOP, RST_IDLE_CODE);
    test_traffic(TRAFFIC_ITEMS);
    repeat (3) begin
      apply_settings(16'($urandom_range(1, 400)),
                     ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 800)),
                     16'($urandom_range(0, 300)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      test_traffic(TRAFFIC_ITEMS);
    end
    test_repeated_drops();

    // Drain and give the pipeline time to show any stray word
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d status words for %0d sent words over %0d register settings",
             checked, sent, settings_used);
    $display("links up %0d, lost %0d, safety stops %0d, uncommanded idles %0d, drops %0d",
             established_seen, lost_seen, stops_seen, idles_seen, drops);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d status words wrong or unexpected", errors);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
